/* design/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants for the servo command line parser
// Character codes, event kinds and the word passed from the parser to the
// output pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned NumSlotsDefault = 9;
  localparam int unsigned MaxLineDefault  = 255;
  localparam logic [15:0] MaxPulseReset   = 16'd2500;

  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChP     = 8'h50;  // 'P'
  localparam logic [7:0] ChT     = 8'h54;  // 'T'
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    EV_PULSE  = 2'd0,
    EV_TIME   = 2'd1,
    EV_COMMIT = 2'd2
  } event_kind_e;

  // One event raised by a character; the slot index travels beside it.
  typedef struct packed {
    logic        valid;
    event_kind_e kind;
    logic [15:0] value;
  } scp_event_t;

endpackage

/* design/scp_table.sv */
// ----------------------------------------------------------------------------
// scp_table: staging table memory
// One write port and one registered read port; entries not yet written
// since reset read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module scp_table #(
  parameter int unsigned NUM_SLOTS = scp_pkg::NumSlotsDefault,
  localparam int unsigned AW       = $clog2(NUM_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);
  import scp_pkg::*;

  logic [15:0]          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  logic [15:0]          rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* design/scp_parse.sv */
// ----------------------------------------------------------------------------
// scp_parse: per-character line parser
// Holds the line state and accumulators and decides the event raised by
// each accepted character.
// ----------------------------------------------------------------------------
module scp_parse #(
  parameter int unsigned NUM_SLOTS = scp_pkg::NumSlotsDefault,
  parameter int unsigned MAX_LINE  = scp_pkg::MaxLineDefault,
  localparam int unsigned AW       = $clog2(NUM_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_i,
  input  logic [15:0]       max_pulse_i,
  output scp_pkg::scp_event_t ev_o,
  output logic [AW-1:0]     slot_o
);
  import scp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINE + 1);

  logic          line_open_q, line_open_d;
  logic          chan_mode_q, chan_mode_d;
  logic          pulse_mode_q, pulse_mode_d;
  logic          time_mode_q, time_mode_d;
  logic [7:0]    ch_acc_q, ch_acc_d;
  logic [15:0]   pulse_acc_q, pulse_acc_d;
  logic [15:0]   time_acc_q, time_acc_d;
  logic [AW-1:0] last_ch_q, last_ch_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          tdig_q, tdig_d;

  logic          is_digit, is_hash, is_p, is_t, is_cr, is_lf;
  logic [3:0]    digit;
  logic [11:0]   ch_next;
  logic [19:0]   pulse_next, time_next;
  logic [15:0]   pulse_clamped, time_sat;
  logic          line_full, ch_in_range;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_hash  = (char_i == ChHash);
  assign is_p     = (char_i == ChP);
  assign is_t     = (char_i == ChT);
  assign is_cr    = (char_i == ChCr);
  assign is_lf    = (char_i == ChLf);
  assign digit    = char_i[3:0];

  // Decimal accumulate: acc * 10 + digit, saturated at the register's limit.
  assign ch_next    = 12'(ch_acc_q) * 12'd10 + 12'(digit);
  assign pulse_next = 20'(pulse_acc_q) * 20'd10 + 20'(digit);
  assign time_next  = 20'(time_acc_q) * 20'd10 + 20'(digit);
  assign time_sat   = (time_next > 20'hFFFF) ? 16'hFFFF : time_next[15:0];

  assign pulse_clamped = (pulse_acc_q > max_pulse_i) ? max_pulse_i : pulse_acc_q;
  assign line_full     = (cnt_q >= CW'(MAX_LINE));
  assign ch_in_range   = (ch_acc_q >= 8'd1) && (ch_acc_q < 8'(NUM_SLOTS));

  always_comb begin
    line_open_d  = line_open_q;
    chan_mode_d  = chan_mode_q;
    pulse_mode_d = pulse_mode_q;
    time_mode_d  = time_mode_q;
    ch_acc_d     = ch_acc_q;
    pulse_acc_d  = pulse_acc_q;
    time_acc_d   = time_acc_q;
    last_ch_d    = last_ch_q;
    cnt_d        = cnt_q;
    tdig_d       = tdig_q;
    ev_o         = '{valid: 1'b0, kind: EV_PULSE, value: '0};
    slot_o       = '0;

    if (line_open_q && (is_lf || line_full)) begin
      line_open_d  = 1'b0;
      chan_mode_d  = 1'b0;
      pulse_mode_d = 1'b0;
      time_mode_d  = 1'b0;
      ch_acc_d     = '0;
      pulse_acc_d  = '0;
      time_acc_d   = '0;
      cnt_d        = '0;
      tdig_d       = 1'b0;
    end else if (line_open_q || is_hash) begin
      line_open_d = 1'b1;
      cnt_d       = cnt_q + CW'(1);
      tdig_d      = 1'b0;

      if (chan_mode_q) begin
        if (is_p) begin
          chan_mode_d = 1'b0;
        end else if (is_digit) begin
          ch_acc_d = (ch_next > 12'd255) ? 8'hFF : ch_next[7:0];
        end
      end

      if (pulse_mode_q) begin
        if (is_t || is_hash) begin
          pulse_mode_d = 1'b0;
          pulse_acc_d  = '0;
          ch_acc_d     = '0;
          if (ch_in_range) begin
            last_ch_d = AW'(ch_acc_q);
            ev_o      = '{valid: 1'b1, kind: EV_PULSE, value: pulse_clamped};
            slot_o    = AW'(ch_acc_q);
          end
        end else if (is_digit) begin
          pulse_acc_d = (pulse_next > 20'hFFFF) ? 16'hFFFF : pulse_next[15:0];
        end
      end

      if (time_mode_q) begin
        if (is_digit) begin
          time_acc_d = time_sat;
          tdig_d     = 1'b1;
          ev_o       = '{valid: 1'b1, kind: EV_TIME, value: time_sat};
        end else if (is_cr && tdig_q) begin
          // Value comes from the staging table read issued with this word.
          ev_o   = '{valid: 1'b1, kind: EV_COMMIT, value: '0};
          slot_o = last_ch_q;
        end
      end

      if (is_hash) begin
        chan_mode_d = 1'b1;
      end
      if (is_p) begin
        pulse_mode_d = 1'b1;
      end
      if (is_t) begin
        time_mode_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open_q  <= 1'b0;
      chan_mode_q  <= 1'b0;
      pulse_mode_q <= 1'b0;
      time_mode_q  <= 1'b0;
      ch_acc_q     <= '0;
      pulse_acc_q  <= '0;
      time_acc_q   <= '0;
      last_ch_q    <= '0;
      cnt_q        <= '0;
      tdig_q       <= 1'b0;
    end else if (accept_i) begin
      line_open_q  <= line_open_d;
      chan_mode_q  <= chan_mode_d;
      pulse_mode_q <= pulse_mode_d;
      time_mode_q  <= time_mode_d;
      ch_acc_q     <= ch_acc_d;
      pulse_acc_q  <= pulse_acc_d;
      time_acc_q   <= time_acc_d;
      last_ch_q    <= last_ch_d;
      cnt_q        <= cnt_d;
      tdig_q       <= tdig_d;
    end
  end

`ifndef SYNTHESIS
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_open_q |-> (cnt_q == '0) && !chan_mode_q && !pulse_mode_q && !time_mode_q)
    else $error("closed line holds parse state");

  a_time_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tdig_q |-> time_mode_q && line_open_q)
    else $error("time digit mark set outside time field");
`endif

endmodule

/* design/servo_command_line_parser.sv */
// ----------------------------------------------------------------------------
// servo_command_line_parser: servo command line parser, one character a word
// A result word passes through stage one and the output register after
// the character that raises it is accepted.
// Throughput: one character per cycle while stage one can move on; the
// staging table read for a commit is pipelined behind the parse stage, so it adds no stall.
// Reset: line state, accumulators and the staging table read as zero;
// max_pulse returns to 2500. No clearing pass is needed.
// ----------------------------------------------------------------------------
module servo_command_line_parser #(
  parameter int unsigned NUM_SLOTS = scp_pkg::NumSlotsDefault,
  parameter int unsigned MAX_LINE  = scp_pkg::MaxLineDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  channel_o,
  output logic [15:0] value_o
);
  import scp_pkg::*;

  localparam int unsigned AW = $clog2(NUM_SLOTS);

  // The max_pulse register; the user must write it only while the block is idle, which the block does not enforce.
  logic [15:0] max_pulse_q;

  // Parse stage outputs for the character on the input this cycle.
  scp_event_t  ev;
  logic [AW-1:0] ev_slot;
  logic        accept;

  // Stage one holds the event while the staging table read (commits only)
  // completes; the output register then parts the two handshakes.
  scp_event_t  s1_q;
  logic [AW-1:0] s1_slot_q;
  logic [15:0] tbl_rdata;
  logic        advance;

  logic        out_valid_q;
  event_kind_e out_kind_q;
  logic [3:0]  out_chan_q;
  logic [15:0] out_value_q;

  // Stage one may move on whenever the output register is free or is being
  // taken this cycle; the input only stalls when stage one cannot move.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_q.valid && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pulse_q <= MaxPulseReset;
    end else if (cfg_we_i) begin
      max_pulse_q <= cfg_wdata_i;
    end
  end

  scp_parse #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_LINE  (MAX_LINE)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (char_in_i),
    .max_pulse_i (max_pulse_q),
    .ev_o        (ev),
    .slot_o      (ev_slot)
  );

  // Pulse and time words are written into the staging table as the
  // character is taken. A commit reads its slot at the same edge; since a
  // character raises at most one event, a write and a read never meet at
  // one edge, and any earlier write has already landed in the array.
  // The read data is held while the commit waits in stage one, because no
  // new character (and so no new read) is taken until stage one moves.
  scp_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && ev.valid && (ev.kind != EV_COMMIT)),
    .waddr_i (ev_slot),
    .wdata_i (ev.value),
    .re_i    (accept && ev.valid && (ev.kind == EV_COMMIT)),
    .raddr_i (ev_slot),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s1_slot_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_q      <= ev;
        s1_slot_q <= ev_slot;
      end else if (advance) begin
        s1_q.valid <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_q.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q  <= s1_q.kind;
      out_chan_q  <= (s1_q.kind == EV_TIME) ? 4'd0 : 4'(s1_slot_q);
      out_value_q <= (s1_q.kind == EV_COMMIT) ? tbl_rdata : s1_q.value;
    end
  end

  // The committed word is the new active-table entry for its channel.
  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign channel_o    = out_chan_q;
  assign value_o      = out_value_q;

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid && !advance |=> s1_q.valid && $stable(s1_slot_q))
    else $error("stage one lost a waiting word");

  a_time_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == EV_TIME) |-> (out_chan_q == 4'd0))
    else $error("time word carries a channel");

  a_pulse_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == EV_PULSE) |-> (out_value_q <= max_pulse_q))
    else $error("pulse word above max_pulse");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the servo command line parser
// Feeds command line characters over the valid/stall input channel and
// checks every result word against a cycle-free behavioural predictor of the
// parser. A short table of directed characters comes first, then three
// phases of random command lines with different idling patterns and pulse
// limits.
// ----------------------------------------------------------------------------
module testbench;
  import scp_pkg::*;

  localparam int unsigned NumSlots    = NumSlotsDefault;
  localparam int unsigned MaxLine     = MaxLineDefault;
  localparam int unsigned PhaseItems  = 500;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned IdleLimit   = 2000;

  // Bit positions of the parse mode flags.
  localparam int FlagChan  = 0;
  localparam int FlagPulse = 1;
  localparam int FlagTime  = 2;

  // One result word as it leaves the parser.
  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  channel;
    logic [15:0] value;
  } event_word_t;

  localparam event_word_t NoEvent = '{kind: EV_PULSE, channel: 4'd0, value: 16'd0};

  // A row of the directed table is either a character or a register write.
  // A character row is checked by the predictor, or against a result typed
  // in beside it, or is known to raise nothing.
  typedef enum logic [0:0] {ROW_CHAR, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {BY_MODEL, TYPED_NONE, TYPED_EVENT} row_check_e;

  typedef struct packed {
    row_op_e     op;
    logic [15:0] data;
    row_check_e  check;
    event_word_t ev;
  } row_t;

  localparam int NumRows = 39;

  // The directed table starts straight after reset, so the pulse limit is
  // still at its reset value until the first register row.
  row_t directed_rows [NumRows] = '{
    // A character before any '#' is ignored.
    '{ROW_CHAR, 16'h0000,    TYPED_NONE,  NoEvent},
    // Commit before any pulse has been staged: the time slot is copied.
    '{ROW_CHAR, 16'(ChHash), BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChT),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("1"),    TYPED_EVENT, '{EV_TIME, 4'd0, 16'd1}},
    '{ROW_CHAR, 16'(ChCr),   TYPED_EVENT, '{EV_COMMIT, 4'd0, 16'd1}},
    '{ROW_CHAR, 16'(ChLf),   BY_MODEL,    NoEvent},
    // A stray all-ones character inside the pulse digits is skipped, and
    // a second 'T' only closes the pulse that is already closed.
    '{ROW_CHAR, 16'(ChHash), BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("3"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChP),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'h00FF,    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChT),    TYPED_EVENT, '{EV_PULSE, 4'd3, 16'd99}},
    '{ROW_CHAR, 16'(ChT),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("5"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChCr),   BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChLf),   BY_MODEL,    NoEvent},
    // With a limit of zero every pulse is clamped to nothing.
    '{ROW_CFG,  16'h0000,    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChHash), BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("8"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChP),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("7"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChHash), TYPED_EVENT, '{EV_PULSE, 4'd8, 16'd0}},
    // The channel saturates at 255 and the pulse for it is dropped.
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChP),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("4"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChHash), BY_MODEL,    NoEvent},
    // Full-scale limit, with the pulse accumulator saturating at 65535.
    '{ROW_CFG,  16'hFFFF,    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("8"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChP),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'("9"),    BY_MODEL,    NoEvent},
    '{ROW_CHAR, 16'(ChT),    TYPED_EVENT, '{EV_PULSE, 4'd8, 16'hFFFF}},
    '{ROW_CHAR, 16'(ChLf),   BY_MODEL,    NoEvent}
  };

  // Everything driven into the parser has a known value from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  char_in_i   = 8'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  event_kind_o;
  logic [3:0]  channel_o;
  logic [15:0] value_o;

  // Idling control. The sender's gap rate belongs to the main process; the
  // receiver's stall rate and the hold-off request are handed over to the
  // receiver process with nonblocking writes.
  int unsigned gap_pct   = 18;
  int unsigned stall_pct = 80;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned idle_cycles = 0;
  int unsigned mismatches  = 0;

  // Result words predicted for accepted characters, oldest first.
  event_word_t expected_events [$];
  event_word_t want;

  // Characters of the command line under construction.
  logic [7:0] line_buf [$];

  // Predictor state, a shadow of the parser's own.
  logic [15:0] m_max_pulse;
  logic        m_line_open;
  logic [2:0]  m_flags;
  logic [7:0]  m_chan_acc;
  logic [15:0] m_pulse_acc;
  logic [15:0] m_time_acc;
  logic [3:0]  m_last_chan;
  int unsigned m_char_count;
  logic        m_time_prev;
  logic [15:0] m_staging [NumSlots];

  servo_command_line_parser #(
    .NUM_SLOTS (NumSlots),
    .MAX_LINE  (MaxLine)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_in_i    (char_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .channel_o    (channel_o),
    .value_o      (value_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // Decimal accumulation with saturation at the given ceiling.
  function automatic logic [31:0] push_digit(logic [31:0] acc, logic [7:0] c,
                                             logic [31:0] ceiling);
    logic [31:0] sum;
    sum = acc * 32'd10 + 32'(c - ChZero);
    return (sum > ceiling) ? ceiling : sum;
  endfunction

  // Ending a line clears the parse state; the staging table and the last
  // staged channel survive it.
  task automatic close_line();
    m_line_open  = 1'b0;
    m_flags      = 3'd0;
    m_chan_acc   = 8'd0;
    m_pulse_acc  = 16'd0;
    m_time_acc   = 16'd0;
    m_char_count = 0;
    m_time_prev  = 1'b0;
  endtask

  // Advances the predictor by one character. taken is low only for a
  // character that the closed line ignores; raised tells whether a result
  // word is due, and ev holds it.
  task automatic parse_char(input logic [7:0] c, output bit taken, output bit raised,
                            output event_word_t ev);
    bit          was_time;
    logic [15:0] clamped;
    logic [3:0]  slot;
    taken    = 1'b1;
    raised   = 1'b0;
    ev       = NoEvent;
    was_time = m_time_prev;
    if (!m_line_open) begin
      if (c != ChHash) begin
        taken = 1'b0;
        return;
      end
      m_line_open = 1'b1;
    end else if (c == ChLf || m_char_count >= MaxLine) begin
      // A line feed ends the line, and so does the character that would
      // make the line too long; either way the character itself is lost.
      close_line();
      return;
    end
    m_char_count++;
    m_time_prev = 1'b0;

    if (m_flags[FlagChan]) begin
      if (c == ChP) begin
        m_flags[FlagChan] = 1'b0;
      end else if (is_digit(c)) begin
        m_chan_acc = 8'(push_digit(32'(m_chan_acc), c, 32'd255));
      end
    end

    if (m_flags[FlagPulse]) begin
      if (c == ChT || c == ChHash) begin
        clamped = (m_pulse_acc > m_max_pulse) ? m_max_pulse : m_pulse_acc;
        m_flags[FlagPulse] = 1'b0;
        // Channel zero and channels beyond the table are dropped silently.
        if (m_chan_acc >= 8'd1 && 32'(m_chan_acc) < NumSlots) begin
          slot = m_chan_acc[3:0];
          m_staging[slot] = clamped;
          m_last_chan = slot;
          ev = '{kind: EV_PULSE, channel: slot, value: clamped};
          raised = 1'b1;
        end
        m_pulse_acc = 16'd0;
        m_chan_acc  = 8'd0;
      end else if (is_digit(c)) begin
        m_pulse_acc = 16'(push_digit(32'(m_pulse_acc), c, 32'd65535));
      end
    end

    if (m_flags[FlagTime]) begin
      if (is_digit(c)) begin
        m_time_acc = 16'(push_digit(32'(m_time_acc), c, 32'd65535));
        m_staging[0] = m_time_acc;
        m_time_prev = 1'b1;
        ev = '{kind: EV_TIME, channel: 4'd0, value: m_time_acc};
        raised = 1'b1;
      end else if (c == ChCr && was_time) begin
        // Only a carriage return right after a time digit commits.
        slot = (32'(m_last_chan) < NumSlots) ? m_last_chan : 4'd0;
        ev = '{kind: EV_COMMIT, channel: slot, value: m_staging[slot]};
        raised = 1'b1;
      end
    end

    if (c == ChHash) m_flags[FlagChan] = 1'b1;
    if (c == ChP) m_flags[FlagPulse] = 1'b1;
    if (c == ChT) m_flags[FlagTime] = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Offers one character and returns at the clock edge that accepts it,
  // with the predictor already moved on. Called at a rising edge.
  task automatic send_char(input logic [7:0] c, output bit taken, output bit raised,
                           output event_word_t ev);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    parse_char(c, taken, raised, ev);
  endtask

  // Stops offering and waits until every predicted word has come back,
  // then keeps waiting for any character still in flight that raises
  // nothing.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The register is only written once the parser has gone quiet.
  task automatic write_max_pulse(input logic [15:0] limit_value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit_value;
    @(posedge clk_i);
    m_max_pulse = limit_value;
    cfg_we_i    <= 1'b0;
  endtask

  // Appends a decimal number to the line, now and then with a stray
  // character slipped in between the digits.
  task automatic add_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) begin
      if ($urandom_range(0, 24) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(digits[i]);
    end
  endtask

  // One phase of random command lines. Most lines are well formed with
  // random channels, pulses and times; the rest are noise, lines with a
  // missing 'P', 'T', CR or LF, and the odd line that runs past the length
  // limit. A third of the way in the receiver is told to hold off for a
  // long stretch; two thirds in the sender pauses until all results are in.
  task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                           input logic [15:0] limit_value);
    int unsigned counted;
    int unsigned lines;
    int unsigned pick;
    logic [7:0]  c;
    bit          taken;
    bit          raised;
    bit          held;
    bit          paused;
    event_word_t ev;
    counted = 0;
    lines   = 0;
    held    = 1'b0;
    paused  = 1'b0;
    write_max_pulse(limit_value);
    gap_pct = sender_pct;
    stall_pct <= receiver_pct;
    while (counted < PhaseItems) begin
      if (!held && counted >= PhaseItems / 3) begin
        hold_req <= hold_req + 1;
        held = 1'b1;
      end
      if (!paused && counted >= 2 * PhaseItems / 3) begin
        wait_idle();
        paused = 1'b1;
      end
      line_buf.delete();
      pick = $urandom_range(0, 99);
      if (lines == 2 || pick < 2) begin
        // Over-long line: anything but a line feed after the opening '#'.
        line_buf.push_back(ChHash);
        repeat ($urandom_range(MaxLine, MaxLine + 20)) begin
          c = 8'($urandom_range(0, 255));
          line_buf.push_back((c == ChLf) ? ChZero : c);
        end
        line_buf.push_back(ChLf);
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          line_buf.push_back(ChHash);
          case ($urandom_range(0, 9))
            0:       add_number(0);
            1:       add_number($urandom_range(9, 999));
            default: add_number($urandom_range(1, 8));
          endcase
          if ($urandom_range(0, 19) != 0) line_buf.push_back(ChP);
          case ($urandom_range(0, 9))
            0:       add_number($urandom_range(0, 9999999));
            1:       add_number($urandom_range(60000, 70000));
            default: add_number($urandom_range(500, 2500));
          endcase
        end
        if ($urandom_range(0, 9) != 0) begin
          line_buf.push_back(ChT);
          if ($urandom_range(0, 9) == 0) add_number($urandom_range(0, 9999999));
          else add_number($urandom_range(0, 5000));
          if ($urandom_range(0, 9) != 0) line_buf.push_back(ChCr);
        end
        if ($urandom_range(0, 9) != 0) line_buf.push_back(ChLf);
      end
      foreach (line_buf[i]) begin
        send_char(line_buf[i], taken, raised, ev);
        if (raised) expected_events.push_back(ev);
        if (taken) counted++;
      end
      lines++;
    end
  endtask

  // Receiver: random stalls at the phase's rate, or a long unbroken
  // hold-off whenever the main process asks for one.
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: every word taken off the output is compared with the
  // oldest prediction still waiting.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result word kind %0d channel %0d value %0d unexpected",
                                  event_kind_o, channel_o, value_o));
      end else begin
        want = expected_events.pop_front();
        if (event_kind_o !== want.kind)
          report_mismatch($sformatf("event kind %0d, expected %0d", event_kind_o, want.kind));
        if (channel_o !== want.channel)
          report_mismatch($sformatf("channel %0d, expected %0d", channel_o, want.channel));
        if (value_o !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", value_o, want.value));
      end
    end
  end

  // Watchdog: too long without any word moving on either channel means the
  // parser has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main
    bit          taken;
    bit          raised;
    event_word_t ev;
    m_max_pulse = MaxPulseReset;
    m_last_chan = 4'd0;
    foreach (m_staging[i]) m_staging[i] = 16'd0;
    close_line();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        write_max_pulse(directed_rows[i].data);
      end else begin
        send_char(directed_rows[i].data[7:0], taken, raised, ev);
        case (directed_rows[i].check)
          BY_MODEL:    if (raised) expected_events.push_back(ev);
          TYPED_EVENT: expected_events.push_back(directed_rows[i].ev);
          default:     ;
        endcase
      end
    end

    // Random phases: sender busy and receiver often stalled, then the other way
    // round, then both flat out.
    run_phase(18, 80, 16'($urandom_range(0, 65535)));
    run_phase(80, 18, 16'd1);
    run_phase(0, 0, 16'hFFFF);

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected result words never arrived",
                                expected_events.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
